// ===== hw/rtl/mbg_pkg.sv =====
// Shared types and constants of the maze backtracker generator.
// Holds function and status codes, cell bit layout, the direction order
// table and the controller/datapath command and status words.
package mbg_pkg;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STEP  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [2:0] ST_STARTED  = 3'd0;
  localparam logic [2:0] ST_CARVED   = 3'd1;
  localparam logic [2:0] ST_BACKED   = 3'd2;
  localparam logic [2:0] ST_FINISHED = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;
  localparam logic [2:0] ST_REJECTED = 3'd5;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  localparam int CB_VIS = 0;
  localparam int CB_N   = 1;
  localparam int CB_S   = 2;
  localparam int CB_E   = 3;
  localparam int CB_W   = 4;

  localparam int CELL_W  = 5;
  localparam int CFG_W   = 5;
  localparam int PERM_MAX = 23;

  localparam logic CFG_GRID_ROWS = 1'b0;
  localparam logic CFG_GRID_COLS = 1'b1;

  typedef logic [3:0][1:0] dir_order_t;

  typedef struct packed {
    logic       capture;
    logic       clr_step;
    logic       start_wr;
    logic       rd_in_cell;
    logic       rd_cur;
    logic       cap_cur;
    logic       try_adv;
    logic       try_rd;
    logic       wr_cur;
    logic       wr_nbr;
    logic       pop;
    logic       pop_top;
    logic       load_out;
    logic [2:0] res_status;
  } mbg_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       in_grid;
    logic       generating;
    logic       perm_ok;
    logic       dir_inb;
    logic       nbr_vis;
    logic       last_try;
    logic       clr_last;
    logic       depth_one;
    logic       out_free;
  } mbg_sts_t;

  function automatic dir_order_t mk_order(input logic [1:0] a, input logic [1:0] b,
                                          input logic [1:0] c, input logic [1:0] d);
    mk_order = {d, c, b, a};
  endfunction

  function automatic dir_order_t perm_order(input logic [4:0] perm);
    dir_order_t o;
    unique case (perm)
      5'd0:    o = mk_order(DIR_N, DIR_S, DIR_E, DIR_W);
      5'd1:    o = mk_order(DIR_N, DIR_S, DIR_W, DIR_E);
      5'd2:    o = mk_order(DIR_N, DIR_E, DIR_S, DIR_W);
      5'd3:    o = mk_order(DIR_N, DIR_E, DIR_W, DIR_S);
      5'd4:    o = mk_order(DIR_N, DIR_W, DIR_S, DIR_E);
      5'd5:    o = mk_order(DIR_N, DIR_W, DIR_E, DIR_S);
      5'd6:    o = mk_order(DIR_S, DIR_N, DIR_E, DIR_W);
      5'd7:    o = mk_order(DIR_S, DIR_N, DIR_W, DIR_E);
      5'd8:    o = mk_order(DIR_S, DIR_E, DIR_N, DIR_W);
      5'd9:    o = mk_order(DIR_S, DIR_E, DIR_W, DIR_N);
      5'd10:   o = mk_order(DIR_S, DIR_W, DIR_N, DIR_E);
      5'd11:   o = mk_order(DIR_S, DIR_W, DIR_E, DIR_N);
      5'd12:   o = mk_order(DIR_E, DIR_N, DIR_S, DIR_W);
      5'd13:   o = mk_order(DIR_E, DIR_N, DIR_W, DIR_S);
      5'd14:   o = mk_order(DIR_E, DIR_S, DIR_N, DIR_W);
      5'd15:   o = mk_order(DIR_E, DIR_S, DIR_W, DIR_N);
      5'd16:   o = mk_order(DIR_E, DIR_W, DIR_N, DIR_S);
      5'd17:   o = mk_order(DIR_E, DIR_W, DIR_S, DIR_N);
      5'd18:   o = mk_order(DIR_W, DIR_N, DIR_S, DIR_E);
      5'd19:   o = mk_order(DIR_W, DIR_N, DIR_E, DIR_S);
      5'd20:   o = mk_order(DIR_W, DIR_S, DIR_N, DIR_E);
      5'd21:   o = mk_order(DIR_W, DIR_S, DIR_E, DIR_N);
      5'd22:   o = mk_order(DIR_W, DIR_E, DIR_N, DIR_S);
      5'd23:   o = mk_order(DIR_W, DIR_E, DIR_S, DIR_N);
      default: o = mk_order(DIR_N, DIR_S, DIR_E, DIR_W);
    endcase
    perm_order = o;
  endfunction

  function automatic logic [CELL_W-1:0] dir_mask(input logic [1:0] d);
    logic [CELL_W-1:0] m;
    m = '0;
    unique case (d)
      DIR_N:   m[CB_N] = 1'b1;
      DIR_S:   m[CB_S] = 1'b1;
      DIR_E:   m[CB_E] = 1'b1;
      DIR_W:   m[CB_W] = 1'b1;
      default: m = '0;
    endcase
    dir_mask = m;
  endfunction

endpackage

// ===== hw/rtl/mbg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mbg_ctrl.sv =====
// Sequencing state machine of the maze backtracker generator.
// Depends on mbg_pkg; drives the datapath by command word, reads its status word.
module mbg_ctrl
  import mbg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mbg_sts_t sts,
  output mbg_cmd_t cmd
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'h0001,
    S_IDLE     = 15'h0002,
    S_DECODE   = 15'h0004,
    S_SWEEP    = 15'h0008,
    S_START_WR = 15'h0010,
    S_READ_RD  = 15'h0020,
    S_RD_CUR   = 15'h0040,
    S_CAP_CUR  = 15'h0080,
    S_TRY      = 15'h0100,
    S_CHECK    = 15'h0200,
    S_WR_CUR   = 15'h0400,
    S_WR_NBR   = 15'h0800,
    S_POP      = 15'h1000,
    S_POP_WAIT = 15'h2000,
    S_EMIT     = 15'h4000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      res_r   <= ST_REJECTED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd            = '0;
    cmd.res_status = res_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        res_nxt   = ST_REJECTED;
        state_nxt = S_EMIT;
        unique case (sts.func)
          FUNC_START: begin
            if (sts.in_grid) begin
              state_nxt = S_SWEEP;
            end
          end
          FUNC_STEP: begin
            if (sts.generating && sts.perm_ok) begin
              state_nxt = S_RD_CUR;
            end
          end
          FUNC_READ: begin
            if (sts.in_grid) begin
              state_nxt = S_READ_RD;
            end
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_SWEEP: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_START_WR;
        end
      end
      S_START_WR: begin
        cmd.start_wr = 1'b1;
        res_nxt      = ST_STARTED;
        state_nxt    = S_EMIT;
      end
      S_READ_RD: begin
        cmd.rd_in_cell = 1'b1;
        res_nxt        = ST_READ;
        state_nxt      = S_EMIT;
      end
      S_RD_CUR: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_CAP_CUR;
      end
      S_CAP_CUR: begin
        cmd.cap_cur = 1'b1;
        state_nxt   = S_TRY;
      end
      S_TRY: begin
        if (sts.dir_inb) begin
          cmd.try_rd = 1'b1;
          state_nxt  = S_CHECK;
        end else if (sts.last_try) begin
          state_nxt = S_POP;
        end else begin
          cmd.try_adv = 1'b1;
        end
      end
      S_CHECK: begin
        if (!sts.nbr_vis) begin
          state_nxt = S_WR_CUR;
        end else if (sts.last_try) begin
          state_nxt = S_POP;
        end else begin
          cmd.try_adv = 1'b1;
          state_nxt   = S_TRY;
        end
      end
      S_WR_CUR: begin
        cmd.wr_cur = 1'b1;
        state_nxt  = S_WR_NBR;
      end
      S_WR_NBR: begin
        cmd.wr_nbr = 1'b1;
        res_nxt    = ST_CARVED;
        state_nxt  = S_EMIT;
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (sts.depth_one) begin
          res_nxt   = ST_FINISHED;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.pop_top = 1'b1;
        res_nxt     = ST_BACKED;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ===== hw/rtl/mbg_datapath.sv =====
// Datapath of the maze backtracker generator: config, item and walk
// registers, cell store and path stack RAMs, and the result word register.
// Depends on mbg_pkg and mbg_ram.
module mbg_datapath
  import mbg_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mbg_cmd_t         cmd,
  output mbg_sts_t         sts,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic [1:0]       in_func,
  input  logic [3:0]       in_cell_row_in,
  input  logic [3:0]       in_cell_col_in,
  input  logic [4:0]       in_perm_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [3:0]       out_cell_row_out,
  output logic [3:0]       out_cell_col_out,
  output logic [1:0]       out_carved_dir,
  output logic             out_open_north,
  output logic             out_open_south,
  output logic             out_open_east,
  output logic             out_open_west,
  output logic             out_cell_visited
);

  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int DW     = $clog2(NCELLS + 1);
  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int RLW    = $clog2(MAX_ROWS + 1);
  localparam int CLW    = $clog2(MAX_COLS + 1);

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    cell_addr = AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  logic [CFG_W-1:0]  rows_cfg_r, cols_cfg_r;
  logic [RLW-1:0]    rows_eff;
  logic [CLW-1:0]    cols_eff;
  logic [1:0]        func_r;
  logic [3:0]        rin_r, cin_r;
  logic [4:0]        perm_r;
  dir_order_t        order_r;
  logic [1:0]        try_idx_r;
  logic [RW-1:0]     top_row_r, nbr_row_r;
  logic [CW-1:0]     top_col_r, nbr_col_r;
  logic [1:0]        nbr_dir_r;
  logic [DW-1:0]     depth_r;
  logic              gen_r;
  logic [CELL_W-1:0] cur_cell_r;
  logic [AW-1:0]     clr_addr_r;
  logic              clr_last;
  logic [1:0]        try_dir;
  logic              dir_inb;
  logic [RW-1:0]     try_row;
  logic [CW-1:0]     try_col;
  logic [RW-1:0]     in_row;
  logic [CW-1:0]     in_col;

  logic              cell_we, cell_re;
  logic [AW-1:0]     cell_waddr, cell_raddr;
  logic [CELL_W-1:0] cell_wdata, cell_rdata;
  logic              stk_we;
  logic [AW-1:0]     stk_waddr, stk_raddr;
  logic [RW+CW-1:0]  stk_wdata, stk_rdata;

  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [3:0]        out_row_r, out_col_r;
  logic [1:0]        out_dir_r;
  logic [CELL_W-1:0] out_cell_r;
  logic [3:0]        res_row, res_col;
  logic [1:0]        res_dir;
  logic [CELL_W-1:0] res_cell;
  logic              out_free;

  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = RLW'(1);
    end else if (int'(rows_cfg_r) > MAX_ROWS) begin
      rows_eff = RLW'(MAX_ROWS);
    end else begin
      rows_eff = RLW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_eff = CLW'(1);
    end else if (int'(cols_cfg_r) > MAX_COLS) begin
      cols_eff = CLW'(MAX_COLS);
    end else begin
      cols_eff = CLW'(cols_cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_W'(16);
      cols_cfg_r <= CFG_W'(16);
    end else if (cfg_we) begin
      if (cfg_index == CFG_GRID_ROWS) begin
        rows_cfg_r <= cfg_wdata;
      end else begin
        cols_cfg_r <= cfg_wdata;
      end
    end
  end

  assign in_row   = RW'(rin_r);
  assign in_col   = CW'(cin_r);
  assign try_dir  = order_r[try_idx_r];
  assign clr_last = (clr_addr_r == AW'(NCELLS - 1));

  always_comb begin
    try_row = top_row_r;
    try_col = top_col_r;
    dir_inb = 1'b0;
    unique case (try_dir)
      DIR_N: begin
        dir_inb = (top_row_r != '0);
        try_row = top_row_r - RW'(1);
      end
      DIR_S: begin
        dir_inb = ((RLW'(top_row_r) + RLW'(1)) < rows_eff);
        try_row = top_row_r + RW'(1);
      end
      DIR_E: begin
        dir_inb = ((CLW'(top_col_r) + CLW'(1)) < cols_eff);
        try_col = top_col_r + CW'(1);
      end
      DIR_W: begin
        dir_inb = (top_col_r != '0);
        try_col = top_col_r - CW'(1);
      end
      default: dir_inb = 1'b0;
    endcase
  end

  // item, walk and stack bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      rin_r   <= in_cell_row_in;
      cin_r   <= in_cell_col_in;
      perm_r  <= in_perm_index;
      order_r <= perm_order(in_perm_index);
    end
    if (cmd.cap_cur) begin
      cur_cell_r <= cell_rdata;
    end
    if (cmd.try_rd) begin
      nbr_row_r <= try_row;
      nbr_col_r <= try_col;
      nbr_dir_r <= try_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      try_idx_r  <= '0;
      top_row_r  <= '0;
      top_col_r  <= '0;
      depth_r    <= '0;
      gen_r      <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.capture) begin
        try_idx_r <= '0;
      end else if (cmd.try_adv) begin
        try_idx_r <= try_idx_r + 2'd1;
      end
      if (cmd.clr_step) begin
        clr_addr_r <= clr_last ? '0 : clr_addr_r + AW'(1);
      end
      if (cmd.start_wr) begin
        top_row_r <= in_row;
        top_col_r <= in_col;
        depth_r   <= DW'(1);
        gen_r     <= 1'b1;
      end else if (cmd.wr_nbr) begin
        top_row_r <= nbr_row_r;
        top_col_r <= nbr_col_r;
        if (depth_r < DW'(NCELLS)) begin
          depth_r <= depth_r + DW'(1);
        end
      end else if (cmd.pop) begin
        depth_r <= depth_r - DW'(1);
        if (depth_r == DW'(1)) begin
          gen_r <= 1'b0;
        end
      end else if (cmd.pop_top) begin
        top_row_r <= stk_rdata[RW+CW-1:CW];
        top_col_r <= stk_rdata[CW-1:0];
      end
    end
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = clr_addr_r;
    cell_wdata = '0;
    priority if (cmd.clr_step) begin
      cell_we = 1'b1;
    end else if (cmd.start_wr) begin
      cell_we    = 1'b1;
      cell_waddr = cell_addr(in_row, in_col);
      cell_wdata = CELL_W'(1) << CB_VIS;
    end else if (cmd.wr_cur) begin
      cell_we    = 1'b1;
      cell_waddr = cell_addr(top_row_r, top_col_r);
      cell_wdata = cur_cell_r | dir_mask(nbr_dir_r);
    end else if (cmd.wr_nbr) begin
      cell_we    = 1'b1;
      cell_waddr = cell_addr(nbr_row_r, nbr_col_r);
      cell_wdata = cell_rdata | dir_mask(nbr_dir_r ^ 2'd1) | (CELL_W'(1) << CB_VIS);
    end else begin
      cell_we = 1'b0;
    end
  end

  always_comb begin
    cell_re    = cmd.rd_in_cell | cmd.rd_cur | cmd.try_rd;
    cell_raddr = cell_addr(try_row, try_col);
    priority if (cmd.rd_in_cell) begin
      cell_raddr = cell_addr(in_row, in_col);
    end else if (cmd.rd_cur) begin
      cell_raddr = cell_addr(top_row_r, top_col_r);
    end else begin
      cell_raddr = cell_addr(try_row, try_col);
    end
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = {in_row, in_col};
    if (cmd.start_wr) begin
      stk_we = 1'b1;
    end else if (cmd.wr_nbr && (depth_r < DW'(NCELLS))) begin
      stk_we    = 1'b1;
      stk_waddr = depth_r[AW-1:0];
      stk_wdata = {nbr_row_r, nbr_col_r};
    end
    stk_raddr = AW'(depth_r - DW'(2));
  end

  mbg_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  mbg_ram #(
    .WIDTH (RW + CW),
    .DEPTH (NCELLS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (cmd.pop),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    res_row  = '0;
    res_col  = '0;
    res_dir  = '0;
    res_cell = '0;
    unique case (cmd.res_status)
      ST_STARTED: begin
        res_row = rin_r;
        res_col = cin_r;
      end
      ST_CARVED: begin
        res_row = 4'(nbr_row_r);
        res_col = 4'(nbr_col_r);
        res_dir = nbr_dir_r;
      end
      ST_BACKED: begin
        res_row = 4'(top_row_r);
        res_col = 4'(top_col_r);
      end
      ST_READ: begin
        res_row  = rin_r;
        res_col  = cin_r;
        res_cell = cell_rdata;
      end
      default: res_row = '0;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= cmd.res_status;
      out_row_r    <= res_row;
      out_col_r    <= res_col;
      out_dir_r    <= res_dir;
      out_cell_r   <= res_cell;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_cell_row_out = out_row_r;
  assign out_cell_col_out = out_col_r;
  assign out_carved_dir   = out_dir_r;
  assign out_open_north   = out_cell_r[CB_N];
  assign out_open_south   = out_cell_r[CB_S];
  assign out_open_east    = out_cell_r[CB_E];
  assign out_open_west    = out_cell_r[CB_W];
  assign out_cell_visited = out_cell_r[CB_VIS];

  always_comb begin
    sts            = '0;
    sts.func       = func_r;
    sts.in_grid    = (int'(rin_r) < int'(rows_eff)) && (int'(cin_r) < int'(cols_eff));
    sts.generating = gen_r;
    sts.perm_ok    = (int'(perm_r) <= PERM_MAX);
    sts.dir_inb    = dir_inb;
    sts.nbr_vis    = cell_rdata[CB_VIS];
    sts.last_try   = (try_idx_r == 2'd3);
    sts.clr_last   = clr_last;
    sts.depth_one  = (depth_r == DW'(1));
    sts.out_free   = out_free;
  end

endmodule

// ===== hw/rtl/maze_backtracker_generator.sv =====
// Top level of the maze backtracker generator: controller plus datapath.
// Depends on mbg_pkg, mbg_ctrl, mbg_datapath (and mbg_ram below it).
//
//   port group   dir  handshake            word
//   in_*         in   in_valid / in_stall  func, cell row/col, perm index
//   out_*        out  out_valid / out_stall status, cell row/col, dir, openings
//   cfg_*        in   cfg_we               grid_rows (index 0), grid_cols (index 1)
//
// Step: one cell RAM read port, one neighbor probe at a time.
// Start: runs a clearing pass over the cell RAM before it writes the start cell.
// Reset: a pass over all MAX_ROWS*MAX_COLS cells clears the cell RAM; in_stall stays high.
// One item is in work at a time; a new word is taken while a result still waits.
// A stalled result holds the next result in S_EMIT until out_stall drops.
module maze_backtracker_generator
  import mbg_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_func,
  input  logic [3:0]       in_cell_row_in,
  input  logic [3:0]       in_cell_col_in,
  input  logic [4:0]       in_perm_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [3:0]       out_cell_row_out,
  output logic [3:0]       out_cell_col_out,
  output logic [1:0]       out_carved_dir,
  output logic             out_open_north,
  output logic             out_open_south,
  output logic             out_open_east,
  output logic             out_open_west,
  output logic             out_cell_visited
);

  mbg_cmd_t cmd;
  mbg_sts_t sts;

  mbg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbg_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_func          (in_func),
    .in_cell_row_in   (in_cell_row_in),
    .in_cell_col_in   (in_cell_col_in),
    .in_perm_index    (in_perm_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_cell_row_out (out_cell_row_out),
    .out_cell_col_out (out_cell_col_out),
    .out_carved_dir   (out_carved_dir),
    .out_open_north   (out_open_north),
    .out_open_south   (out_open_south),
    .out_open_east    (out_open_east),
    .out_open_west    (out_open_west),
    .out_cell_visited (out_cell_visited)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for maze_backtracker_generator: directed and random
// carving walks, checked word by word against an in-bench maze predictor.
// Depends on mbg_pkg and the RTL of maze_backtracker_generator.
`timescale 1ns / 1ps

module testbench
  import mbg_pkg::*;
();

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int GRID_MAX = 16;
  localparam int CELL_COUNT = 256;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] row;
    logic [3:0] col;
    logic [1:0] dir;
    logic       north;
    logic       south;
    logic       east;
    logic       west;
    logic       visited;
  } maze_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_func;
  logic [3:0]       in_cell_row_in;
  logic [3:0]       in_cell_col_in;
  logic [4:0]       in_perm_index;
  logic             out_valid;
  logic             out_stall;
  logic [2:0]       out_status;
  logic [3:0]       out_cell_row_out;
  logic [3:0]       out_cell_col_out;
  logic [1:0]       out_carved_dir;
  logic             out_open_north;
  logic             out_open_south;
  logic             out_open_east;
  logic             out_open_west;
  logic             out_cell_visited;

  maze_backtracker_generator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_cell_row_in   (in_cell_row_in),
    .in_cell_col_in   (in_cell_col_in),
    .in_perm_index    (in_perm_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_cell_row_out (out_cell_row_out),
    .out_cell_col_out (out_cell_col_out),
    .out_carved_dir   (out_carved_dir),
    .out_open_north   (out_open_north),
    .out_open_south   (out_open_south),
    .out_open_east    (out_open_east),
    .out_open_west    (out_open_west),
    .out_cell_visited (out_cell_visited)
  );

  logic [CELL_W-1:0] maze_cells [CELL_COUNT];
  logic [7:0]        walk_stack [CELL_COUNT];
  int                walk_depth;
  bit                walk_active;
  logic [CFG_W-1:0]  rows_reg;
  logic [CFG_W-1:0]  cols_reg;

  maze_result_t expected_results [$];
  int           errors;
  int           sent_words;
  bit           idle_on;
  bit           stall_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int used_extent(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    return (v > GRID_MAX) ? GRID_MAX : int'(v);
  endfunction

  function automatic maze_result_t predict_maze_result(input logic [1:0] f,
                                                       input logic [3:0] r_in,
                                                       input logic [3:0] c_in,
                                                       input logic [4:0] perm);
    maze_result_t      res;
    int                rows, cols, k, pick, weight, r, c, nr, nc, i, j;
    logic [1:0]        pool [4];
    logic [1:0]        order [4];
    logic [7:0]        cur, nidx, top;
    logic [CELL_W-1:0] here, there;
    bit                blocked;
    res = '0;
    res.status = ST_REJECTED;
    rows = used_extent(rows_reg);
    cols = used_extent(cols_reg);
    case (f)
      FUNC_START: begin
        if (r_in < rows && c_in < cols) begin
          for (i = 0; i < CELL_COUNT; i++) maze_cells[i] = '0;
          maze_cells[{r_in, c_in}] = CELL_W'(1) << CB_VIS;
          walk_stack[0] = {r_in, c_in};
          walk_depth = 1;
          walk_active = 1'b1;
          res.status = ST_STARTED;
          res.row = r_in;
          res.col = c_in;
        end
      end
      FUNC_READ: begin
        if (r_in < rows && c_in < cols) begin
          res.status = ST_READ;
          res.row = r_in;
          res.col = c_in;
          res.north = maze_cells[{r_in, c_in}][CB_N];
          res.south = maze_cells[{r_in, c_in}][CB_S];
          res.east = maze_cells[{r_in, c_in}][CB_E];
          res.west = maze_cells[{r_in, c_in}][CB_W];
          res.visited = maze_cells[{r_in, c_in}][CB_VIS];
        end
      end
      FUNC_STEP: begin
        if (walk_active && perm <= PERM_MAX && walk_depth > 0) begin
          pool = '{DIR_N, DIR_S, DIR_E, DIR_W};
          k = int'(perm);
          for (i = 0; i < 3; i++) begin
            weight = (i == 0) ? 6 : ((i == 1) ? 2 : 1);
            pick = k / weight;
            k = k % weight;
            order[i] = pool[pick];
            for (j = pick; j < 3 - i; j++) pool[j] = pool[j + 1];
          end
          order[3] = pool[0];
          cur = walk_stack[walk_depth - 1];
          r = int'(cur[7:4]);
          c = int'(cur[3:0]);
          for (i = 0; i < 4; i++) begin
            if (res.status == ST_REJECTED) begin
              nr = r;
              nc = c;
              case (order[i])
                DIR_N: begin
                  blocked = (r == 0);
                  nr = r - 1;
                  here = CELL_W'(1) << CB_N;
                  there = CELL_W'(1) << CB_S;
                end
                DIR_S: begin
                  blocked = (r + 1 >= rows);
                  nr = r + 1;
                  here = CELL_W'(1) << CB_S;
                  there = CELL_W'(1) << CB_N;
                end
                DIR_E: begin
                  blocked = (c + 1 >= cols);
                  nc = c + 1;
                  here = CELL_W'(1) << CB_E;
                  there = CELL_W'(1) << CB_W;
                end
                default: begin
                  blocked = (c == 0);
                  nc = c - 1;
                  here = CELL_W'(1) << CB_W;
                  there = CELL_W'(1) << CB_E;
                end
              endcase
              if (!blocked) begin
                nidx = {nr[3:0], nc[3:0]};
                if (!maze_cells[nidx][CB_VIS]) begin
                  maze_cells[cur] = maze_cells[cur] | here;
                  maze_cells[nidx] = maze_cells[nidx] | there | (CELL_W'(1) << CB_VIS);
                  if (walk_depth < CELL_COUNT) begin
                    walk_stack[walk_depth] = nidx;
                    walk_depth++;
                  end
                  res.status = ST_CARVED;
                  res.row = nr[3:0];
                  res.col = nc[3:0];
                  res.dir = order[i];
                end
              end
            end
          end
          if (res.status == ST_REJECTED) begin
            walk_depth--;
            if (walk_depth == 0) begin
              walk_active = 1'b0;
              res.status = ST_FINISHED;
            end else begin
              top = walk_stack[walk_depth - 1];
              res.status = ST_BACKED;
              res.row = top[7:4];
              res.col = top[3:0];
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    maze_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with none expected, status %0d", out_status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", int'(want.status), int'(out_status));
          check_field("cell_row_out", int'(want.row), int'(out_cell_row_out));
          check_field("cell_col_out", int'(want.col), int'(out_cell_col_out));
          check_field("carved_dir", int'(want.dir), int'(out_carved_dir));
          check_field("open_north", int'(want.north), int'(out_open_north));
          check_field("open_south", int'(want.south), int'(out_open_south));
          check_field("open_east", int'(want.east), int'(out_open_east));
          check_field("open_west", int'(want.west), int'(out_open_west));
          check_field("cell_visited", int'(want.visited), int'(out_cell_visited));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_ROWS) rows_reg = cfg_wdata;
        else cols_reg = cfg_wdata;
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_maze_result(in_func, in_cell_row_in,
                                                       in_cell_col_in, in_perm_index));
    end
  end

  initial begin : result_stall
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_stall = 1'b0;
    end
  end

  task automatic send_word(input logic [1:0] f, input logic [3:0] r, input logic [3:0] c,
                           input logic [4:0] perm);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_func = f;
    in_cell_row_in = r;
    in_cell_col_in = c;
    in_perm_index = perm;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    sent_words++;
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    wait_drain();
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
  endtask

  function automatic logic [CFG_W-1:0] random_extent();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return CFG_W'($urandom_range(17, 31));
      2:       return CFG_W'(GRID_MAX);
      3, 4:    return CFG_W'($urandom_range(7, 15));
      default: return CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic read_random_cell();
    send_word(FUNC_READ, 4'($urandom_range(0, used_extent(rows_reg) - 1)),
              4'($urandom_range(0, used_extent(cols_reg) - 1)), 5'($urandom_range(0, 31)));
  endtask

  task automatic start_random_cell();
    send_word(FUNC_START, 4'($urandom_range(0, used_extent(rows_reg) - 1)),
              4'($urandom_range(0, used_extent(cols_reg) - 1)), 5'($urandom_range(0, 31)));
  endtask

  task automatic run_maze_phase(input int max_steps);
    int n, sel;
    set_grid(random_extent(), random_extent());
    if (!walk_active || $urandom_range(0, 4) != 0) begin
      if ($urandom_range(0, 9) == 0)
        send_word(FUNC_START, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  5'($urandom_range(0, 31)));
      start_random_cell();
    end
    n = 0;
    while (walk_active && n < max_steps) begin
      sel = $urandom_range(0, 99);
      if (sel < 80)
        send_word(FUNC_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  5'($urandom_range(0, PERM_MAX)));
      else if (sel < 88)
        read_random_cell();
      else if (sel < 92)
        send_word(FUNC_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  5'($urandom_range(PERM_MAX + 1, 31)));
      else if (sel < 95)
        send_word(FUNC_READ, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  5'($urandom_range(0, 31)));
      else if (sel < 97)
        send_word(FUNC_NONE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  5'($urandom_range(0, 31)));
      else if (sel < 99)
        start_random_cell();
      else
        n = max_steps;
      n++;
    end
    if (!walk_active && $urandom_range(0, 1) == 0)
      send_word(FUNC_STEP, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                5'($urandom_range(0, PERM_MAX)));
    repeat ($urandom_range(2, 6)) read_random_cell();
  endtask

  task automatic test_directed_basics();
    int n;
    send_word(FUNC_READ, 4'd0, 4'd0, 5'd0);
    send_word(FUNC_STEP, 4'd0, 4'd0, 5'd0);
    send_word(FUNC_NONE, 4'd15, 4'd15, 5'd31);
    set_grid(5'd3, 5'd2);
    send_word(FUNC_START, 4'd3, 4'd0, 5'd0);
    send_word(FUNC_READ, 4'd2, 4'd2, 5'd0);
    send_word(FUNC_START, 4'd2, 4'd1, 5'd0);
    send_word(FUNC_STEP, 4'd0, 4'd0, 5'd31);
    send_word(FUNC_STEP, 4'd0, 4'd0, 5'd24);
    n = 0;
    while (walk_active && n < 20) begin
      send_word(FUNC_STEP, 4'd0, 4'd0, (n % 2) ? 5'd23 : 5'd0);
      n++;
    end
    send_word(FUNC_STEP, 4'd0, 4'd0, 5'd0);
    send_word(FUNC_READ, 4'd2, 4'd1, 5'd0);
    send_word(FUNC_READ, 4'd0, 4'd0, 5'd0);
  endtask

  task automatic test_register_extremes();
    set_grid(5'd0, 5'd0);
    send_word(FUNC_START, 4'd0, 4'd0, 5'd0);
    send_word(FUNC_STEP, 4'd0, 4'd0, 5'd12);
    send_word(FUNC_READ, 4'd0, 4'd0, 5'd0);
    send_word(FUNC_READ, 4'd0, 4'd1, 5'd0);
  endtask

  task automatic test_shrunken_grid();
    set_grid(5'd31, 5'd17);
    send_word(FUNC_START, 4'd15, 4'd15, 5'd0);
    repeat (3) send_word(FUNC_STEP, 4'd0, 4'd0, 5'($urandom_range(0, PERM_MAX)));
    set_grid(5'd2, 5'd2);
    repeat (3) send_word(FUNC_STEP, 4'd0, 4'd0, 5'($urandom_range(0, PERM_MAX)));
    send_word(FUNC_READ, 4'd15, 4'd15, 5'd0);
    send_word(FUNC_READ, 4'd1, 4'd1, 5'd0);
  endtask

  task automatic test_random_mazes();
    while (sent_words < 1650) begin
      idle_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      run_maze_phase(400);
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    stall_on = 1'b0;
    while (sent_words < 1800) run_maze_phase(60);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_func = '0;
    in_cell_row_in = '0;
    in_cell_col_in = '0;
    in_perm_index = '0;
    out_stall = 1'b0;
    errors = 0;
    sent_words = 0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < CELL_COUNT; i++) begin
      maze_cells[i] = '0;
      walk_stack[i] = '0;
    end
    walk_depth = 0;
    walk_active = 1'b0;
    rows_reg = CFG_W'(GRID_MAX);
    cols_reg = CFG_W'(GRID_MAX);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed_basics();
    test_register_extremes();
    test_shrunken_grid();
    test_random_mazes();
    test_steady_stream();

    wait_drain();
    repeat (32) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #(50_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== maze_backtracker_generator.f =====
hw/rtl/mbg_pkg.sv
hw/rtl/mbg_ram.sv
hw/rtl/mbg_ctrl.sv
hw/rtl/mbg_datapath.sv
hw/rtl/maze_backtracker_generator.sv
sim/testbench.sv
